FILE: sv/sha256_byte_stream_hasher_assert.svh
// Assertion macros for the SHA-256 byte stream hasher.
// Used by the top level only; needs clk and rst in scope.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
// implication checked on every edge out of reset
`define SHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

FILE: sv/sha_pkg.sv
// Package for the SHA-256 byte stream hasher: constants, round table, helpers.
// No dependencies.
package sha_pkg;
  localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // handshake from control to round core
  typedef struct packed {
    logic start;
    logic init;   // reload the chaining words with the initial values
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;
endpackage

FILE: sv/sha_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module sha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/sha_core.sv
// Round core: 64 rounds, each after its schedule reads, words held in a 16-entry RAM.
// Depends on sha_pkg and sha_ram. Block words are written into the RAM by the caller.
module sha_core
  import sha_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  core_ctl_t        ctl,
  output core_sts_t        sts,
  // word port into the schedule RAM while the core is idle
  input  logic             ld_we,
  input  logic [3:0]       ld_addr,
  input  logic [31:0]      ld_data,
  output logic [31:0]      chain [8]
);
  // rounds 0..15 read W[r] then run the round; rounds 16..63 read w16, w15, w7
  // and w2 over four phases of the one read port, then run the round and write back
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_RND  = 5'b00100,
    S_FIN  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t      state;
  logic [5:0]  rnd;
  logic [1:0]  ph;
  logic [31:0] wa, wb, wc;      // gathered w16, w15, w7
  logic [31:0] v [8];
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;
  logic [31:0] w, g0, g1, s0, s1, t1, t2, mj, ch;

  sha_ram #(.WIDTH(32), .DEPTH(16)) u_sched (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // read order for round >= 16: w16, w15, w7, w2 (one per phase, read data registered)
  always_comb begin
    raddr = rnd[3:0];
    if (rnd >= 6'd16) begin
      case (ph)
        2'd0:    raddr = rnd[3:0];
        2'd1:    raddr = 4'(rnd - 6'd15);
        2'd2:    raddr = 4'(rnd - 6'd7);
        default: raddr = 4'(rnd - 6'd2);
      endcase
    end
    g0 = rotr(wb, 7) ^ rotr(wb, 18) ^ (wb >> 3);
    g1 = rotr(rdata, 17) ^ rotr(rdata, 19) ^ (rdata >> 10);
    w  = (rnd < 6'd16) ? rdata : g1 + wc + g0 + wa;
    s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + s1 + ch + ROUND_K[rnd] + w;
    t2 = s0 + mj;
    we    = ld_we;
    waddr = ld_addr;
    wdata = ld_data;
    if (state == S_RND && rnd >= 6'd16) begin
      we    = 1'b1;
      waddr = rnd[3:0];
      wdata = w;
    end
  end

  assign sts.busy = (state != S_IDLE);
  assign sts.done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd   <= '0;
      ph    <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= IV[i];
    end else begin
      case (state)
        S_IDLE: if (ctl.init) begin
          for (int i = 0; i < 8; i++) chain[i] <= IV[i];
        end else if (ctl.start) begin
          for (int i = 0; i < 8; i++) v[i] <= chain[i];
          rnd   <= '0;
          ph    <= '0;
          state <= S_RD;
        end
        S_RD: begin
          // rdata shows the word addressed last cycle
          if (rnd >= 6'd16) begin
            case (ph)
              2'd1:    wa <= rdata;
              2'd2:    wb <= rdata;
              2'd3:    wc <= rdata;
              default: ;
            endcase
            ph <= ph + 2'd1;
            if (ph == 2'd3) state <= S_RND;
          end else begin
            state <= S_RND;
          end
        end
        S_RND: begin
          for (int i = 7; i > 0; i--) v[i] <= v[i-1];
          v[4] <= v[3] + t1;
          v[0] <= t1 + t2;
          rnd  <= rnd + 6'd1;
          ph   <= '0;
          state <= (rnd == 6'd63) ? S_FIN : S_RD;
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher.
// Input channel s_axis: one beat per item; tdata = {end_of_message, has_byte, data_byte}
// (data_byte in bits 7:0, has_byte bit 8, end_of_message bit 9, zero filled to 16 bits).
// Output channel m_axis: tdata = digest_word, tuser = word_index, tlast = last_word.
// Bytes gather into a 32-bit word; each completed word is written into the schedule
// RAM of the round core. A full block runs 64 rounds; rounds 0..15 read one schedule
// word and rounds 16..63 four (from the one-read-port schedule memory) before the
// round. Byte beats that do not close a block do not stall the input. An end beat
// pads (word writes up to the last word of the block), compresses once or twice, then
// shows eight digest words, one per beat; the output register holds while m_axis_tready
// is low and no input is taken until all eight have gone. The chaining words then
// return to the initial values. Reset is synchronous: it clears the fill and bit
// counters and loads the initial values; the block is ready in the cycle after.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // data_byte[7:0], has_byte[8], end_of_message[9]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // digest_word[31:0]
  output logic [2:0]  m_axis_tuser,  // word_index[2:0]
  output logic        m_axis_tlast
);
  typedef enum logic [5:0] {
    T_IN   = 6'b000001,
    T_CMP  = 6'b000010,
    T_PAD  = 6'b000100,
    T_CMP2 = 6'b001000,
    T_OUT  = 6'b010000,
    T_CLR  = 6'b100000
  } tstate_t;

  tstate_t     state;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [63:0] total;
  logic [31:0] acc;
  logic        fin;     // end pending after a block compress
  logic        second;  // pad in progress builds the length block
  logic [3:0]  pw;      // pad word index
  logic [2:0]  oidx;
  core_ctl_t   ctl;
  core_sts_t   sts;
  logic        ld_we;
  logic [3:0]  ld_addr;
  logic [31:0] ld_data, acc_next, pad_word;
  logic [31:0] chain [8];
  logic        take, hb, eom;
  logic [5:0]  pend;

  sha_core u_core (
    .clk, .rst, .ctl, .sts, .ld_we, .ld_addr, .ld_data, .chain
  );

  assign s_axis_tready = (state == T_IN) && !rst;
  assign take = s_axis_tvalid && s_axis_tready;
  assign hb   = s_axis_tdata[8];
  assign eom  = s_axis_tdata[9];

  // pad word for word pw given pending bytes in fill
  always_comb begin
    pad_word = '0;
    for (int b = 0; b < 4; b++) begin
      if ({pw, 2'(b)} < fill) pad_word[31-8*b -: 8] = acc[31-8*b -: 8];
      else if ({pw, 2'(b)} == fill && !second) pad_word[31-8*b -: 8] = PAD_MARK;
    end
    if (pw == 4'd14 && (second || fill < 6'd56)) pad_word = total[63:32];
    if (pw == 4'd15 && (second || fill < 6'd56)) pad_word = total[31:0];
    if (second) begin
      if (pw < 4'd14) pad_word = '0;
    end
  end

  always_comb begin
    acc_next = acc;
    acc_next[31 - 8*fill[1:0] -: 8] = s_axis_tdata[7:0];
    ld_we   = 1'b0;
    ld_addr = fill[5:2];
    ld_data = acc_next;
    pend    = fill + 6'd1;
    if (state == T_IN && take && hb && fill[1:0] == 2'd3) ld_we = 1'b1;
    if (state == T_PAD) begin
      ld_we   = 1'b1;
      ld_addr = pw;
      ld_data = pad_word;
    end
    ctl.start = (state == T_CMP || state == T_CMP2) && !sts.busy;
    ctl.init  = (state == T_CLR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IN;
      fill   <= '0;
      bits   <= '0;
      fin    <= 1'b0;
      second <= 1'b0;
      pw     <= '0;
      oidx   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        T_IN: if (take) begin
          if (hb) begin
            acc  <= acc_next;
            fill <= pend;
            if (fill == 6'd63) begin
              bits  <= bits + 64'd512;
              fin   <= eom;
              state <= T_CMP;
            end else if (eom) begin
              total <= bits + {55'd0, pend, 3'd0};
              pw    <= pend[5:2];
              state <= T_PAD;
            end
          end else if (eom) begin
            total <= bits + {55'd0, fill, 3'd0};
            pw    <= fill[5:2];
            state <= T_PAD;
          end
        end
        T_PAD: begin
          // words before pw already hold message bytes; mask partial word
          pw <= pw + 4'd1;
          if (pw == 4'd15) state <= T_CMP2;
        end
        T_CMP, T_CMP2: if (sts.done) begin
          if (state == T_CMP) begin
            fill <= '0;
            if (fin) begin
              fin   <= 1'b0;
              total <= bits;
              pw    <= '0;
              state <= T_PAD;
            end else begin
              state <= T_IN;
            end
          end else if (fill >= 6'd56 && !second) begin
            second <= 1'b1;
            pw     <= '0;
            state  <= T_PAD;
          end else begin
            oidx  <= '0;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= chain[0];
            m_axis_tuser  <= '0;
            m_axis_tlast  <= 1'b0;
            state <= T_OUT;
          end
        end
        T_OUT: if (m_axis_tready) begin
          if (oidx == 3'd7) begin
            m_axis_tvalid <= 1'b0;
            state <= T_CLR;
          end else begin
            oidx <= oidx + 3'd1;
            m_axis_tdata <= chain[oidx + 3'd1];
            m_axis_tuser <= oidx + 3'd1;
            m_axis_tlast <= (oidx == 3'd6);
          end
        end
        // core reloads the initial chaining words in this cycle
        T_CLR: begin
          fill   <= '0;
          bits   <= '0;
          second <= 1'b0;
          state  <= T_IN;
        end
        default: state <= T_IN;
      endcase
    end
  end

  `include "sha256_byte_stream_hasher_assert.svh"

  `SHA_ASSERT_IMP(a_no_in_while_out, m_axis_tvalid, !s_axis_tready)
  `SHA_ASSERT_IMP(a_last_idx, m_axis_tvalid && m_axis_tlast, m_axis_tuser == 3'd7)
  `SHA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule
